// ===== rtl/ttcf_pkg.sv =====
// Shared types and constants of the scrolling text console.
`default_nettype none

package ttcf_pkg;

    // Default store geometry
    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 64;

    // Item kinds (the fourth code is a no-op that only reports the cursor)
    localparam logic [1:0] KIND_FEED  = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Character codes
    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_QMARK = 7'h3F;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_BS    = 8'h08;

    // Register map (index taken from paddr[2])
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;
    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [6:0] ROWS_RESET = 7'd25;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_in;
        logic [5:0] read_row;
        logic [6:0] read_col;
    } ttcf_in_t;

    typedef struct packed {
        logic       cell_written;
        logic [5:0] cell_row;
        logic [6:0] cell_col;
        logic [6:0] cell_char;
        logic       scrolled;
        logic [5:0] cursor_row;
        logic [6:0] cursor_col;
        logic [6:0] read_char;
    } ttcf_out_t;

endpackage

`default_nettype wire

// ===== rtl/ttcf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ttcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, register read data on enable
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/text_terminal_char_feed_top.sv =====
// Top level of the scrolling text console: control, cursor, ring base and screen store.
`default_nettype none

// A character-cell console. Each item feeds one byte, clears the screen or
// reads one cell, and yields exactly one result item. An item passes through
// an accept step (which also launches the screen read) and an execute step in
// which the store is written and the result is registered. A feed that writes
// into a row that has not been written since reset, a clear or the scroll that
// brought it to the bottom first fills all MAX_COLS cells of that row with
// spaces, one cell per cycle over the single write port of the screen RAM.
// Clear and scroll themselves take no extra time; per-row valid flags make
// untouched rows read as spaces, so no clearing pass follows reset. A new item
// is accepted while the previous result still waits in the output register.
module text_terminal_char_feed_top
    import ttcf_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Input items
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire ttcf_in_t    s_data,
    // Result items
    output logic             m_valid,
    input  wire logic        m_ready,
    output ttcf_out_t        m_data
);

    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DEPTH = ((MAX_ROWS > 1) ? MAX_ROWS : 2) * (2 ** CW);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP
    } state_t;

    // Ring row: (base + r) mod MAX_ROWS, both inputs below MAX_ROWS
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] base,
                                               input logic [RW-1:0] r);
        logic [RW:0] sum;
        sum = {1'b0, base} + {1'b0, r};
        if (32'(sum) >= MAX_ROWS) begin
            sum = sum - (RW+1)'(MAX_ROWS);
        end
        return sum[RW-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [7:0] cols_reg;
    logic [6:0] rows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= COLS_RESET;
            rows_reg <= ROWS_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_COLS) begin
                cols_reg <= pwdata[7:0];
            end else begin
                rows_reg <= pwdata[6:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_COLS) ? {24'd0, cols_reg} : {25'd0, rows_reg};

    // Effective geometry: zero acts as one, oversize acts as the maximum
    logic [CW:0] cols_eff;
    logic [RW:0] rows_eff;

    always_comb begin
        if (cols_reg == 8'd0) begin
            cols_eff = (CW+1)'(1);
        end else if (32'(cols_reg) > MAX_COLS) begin
            cols_eff = (CW+1)'(MAX_COLS);
        end else begin
            cols_eff = (CW+1)'(cols_reg);
        end
        if (rows_reg == 7'd0) begin
            rows_eff = (RW+1)'(1);
        end else if (32'(rows_reg) > MAX_ROWS) begin
            rows_eff = (RW+1)'(MAX_ROWS);
        end else begin
            rows_eff = (RW+1)'(rows_reg);
        end
    end

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    state_t             state_reg, state_next;
    ttcf_in_t           item_reg, item_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [RW-1:0]      line_reg, line_next;
    logic [RW-1:0]      base_reg, base_next;
    logic [MAX_ROWS-1:0] rowvalid_reg, rowvalid_next;
    logic [RW-1:0]      sweep_row_reg, sweep_row_next;
    logic [CW-1:0]      sweep_cnt_reg, sweep_cnt_next;
    logic               m_valid_reg, m_valid_next;
    ttcf_out_t          m_data_reg, m_data_next;

    // Screen RAM
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [6:0]         ram_wdata, ram_rdata;

    ttcf_ram #(
        .WIDTH(7),
        .DEPTH(DEPTH)
    ) u_screen (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Feed decode on the held item
    logic [CW-1:0] ccol;
    logic [RW-1:0] cline;
    logic [6:0]    fchar;
    logic          is_lf, is_cr, is_bs, plain;
    logic          wr_en;
    logic [CW-1:0] wr_col;
    logic [6:0]    wr_char;
    logic [RW-1:0] wr_phys;
    logic [CW:0]   col_adv;
    logic          lf_do, at_bottom, scroll;
    logic [RW-1:0] base_inc;
    logic [RW-1:0] bottom_phys;
    logic [RW-1:0] feed_line;
    logic [CW-1:0] feed_col;
    logic          need_sweep;
    logic          out_free;
    logic          rd_in_range;
    logic [RW-1:0] rd_phys;
    logic [6:0]    rd_char;

    always_comb begin
        // Clamp cursor to the geometry in use
        ccol  = ((CW+1)'(col_reg) >= cols_eff) ? CW'(cols_eff - (CW+1)'(1)) : col_reg;
        cline = ((RW+1)'(line_reg) >= rows_eff) ? RW'(rows_eff - (RW+1)'(1)) : line_reg;

        fchar = item_reg.byte_in[7] ? CHAR_QMARK : item_reg.byte_in[6:0];
        is_lf = (item_reg.byte_in == BYTE_LF);
        is_cr = (item_reg.byte_in == BYTE_CR);
        is_bs = (item_reg.byte_in == BYTE_BS);
        plain = !is_lf && !is_cr && !is_bs;

        wr_en   = is_bs ? (ccol != '0) : plain;
        wr_col  = is_bs ? (ccol - CW'(1)) : ccol;
        wr_char = is_bs ? CHAR_SPACE : fchar;
        wr_phys = phys_row(base_reg, cline);

        // Advance and wrap
        col_adv   = (CW+1)'(ccol) + (CW+1)'(1);
        lf_do     = is_lf || (plain && (col_adv == cols_eff));
        at_bottom = ((RW+1)'(cline) + (RW+1)'(1)) >= rows_eff;
        scroll    = lf_do && at_bottom;
        base_inc  = phys_row(base_reg, RW'(1 % MAX_ROWS));
        bottom_phys = phys_row(base_inc, RW'(rows_eff - (RW+1)'(1)));

        if (lf_do) begin
            feed_line = at_bottom ? RW'(rows_eff - (RW+1)'(1)) : (cline + RW'(1));
        end else begin
            feed_line = cline;
        end
        if (lf_do || is_cr) begin
            feed_col = '0;
        end else if (is_bs && (ccol != '0)) begin
            feed_col = ccol - CW'(1);
        end else if (plain) begin
            feed_col = col_adv[CW-1:0];
        end else begin
            feed_col = ccol;
        end

        need_sweep = (item_reg.kind == KIND_FEED) && wr_en && !rowvalid_reg[wr_phys];
        out_free   = !m_valid_reg || m_ready;

        // Read: out-of-store cells and unwritten rows read as spaces
        rd_in_range = (32'(item_reg.read_row) < MAX_ROWS) && (32'(item_reg.read_col) < MAX_COLS);
        rd_phys     = phys_row(base_reg, RW'(item_reg.read_row));
        rd_char     = (rd_in_range && rowvalid_reg[rd_phys]) ? ram_rdata : CHAR_SPACE;
    end

    // Launch the screen read with the accept
    assign s_ready   = (state_reg == ST_IDLE);
    assign ram_re    = s_valid && s_ready && (s_data.kind == KIND_READ);
    assign ram_raddr = {phys_row(base_reg, RW'(s_data.read_row)), CW'(s_data.read_col)};

    // Next-state logic
    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        col_next       = col_reg;
        line_next      = line_reg;
        base_next      = base_reg;
        rowvalid_next  = rowvalid_reg;
        sweep_row_next = sweep_row_reg;
        sweep_cnt_next = sweep_cnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = {wr_phys, wr_col};
        ram_wdata      = wr_char;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (need_sweep) begin
                    // Fill the stale row with spaces before writing into it
                    sweep_row_next = wr_phys;
                    sweep_cnt_next = '0;
                    state_next     = ST_SWEEP;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    state_next   = ST_IDLE;
                    case (item_reg.kind)
                        KIND_FEED: begin
                            ram_we    = wr_en;
                            col_next  = feed_col;
                            line_next = feed_line;
                            if (scroll) begin
                                base_next = base_inc;
                                rowvalid_next[bottom_phys] = 1'b0;
                            end
                            m_data_next.cell_written = wr_en;
                            m_data_next.cell_row     = wr_en ? 6'(cline) : 6'd0;
                            m_data_next.cell_col     = wr_en ? 7'(wr_col) : 7'd0;
                            m_data_next.cell_char    = wr_en ? wr_char : 7'd0;
                            m_data_next.scrolled     = scroll;
                            m_data_next.cursor_row   = 6'(feed_line);
                            m_data_next.cursor_col   = 7'(feed_col);
                        end
                        KIND_CLEAR: begin
                            col_next      = '0;
                            line_next     = '0;
                            base_next     = '0;
                            rowvalid_next = '0;
                        end
                        KIND_READ: begin
                            m_data_next.cursor_row = 6'(line_reg);
                            m_data_next.cursor_col = 7'(col_reg);
                            m_data_next.read_char  = rd_char;
                        end
                        default: begin
                            m_data_next.cursor_row = 6'(line_reg);
                            m_data_next.cursor_col = 7'(col_reg);
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = {sweep_row_reg, sweep_cnt_reg};
                ram_wdata = CHAR_SPACE;
                sweep_cnt_next = sweep_cnt_reg + CW'(1);
                if (32'(sweep_cnt_reg) == MAX_COLS - 1) begin
                    rowvalid_next[sweep_row_reg] = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, cursor, ring base, row flags and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            col_reg      <= '0;
            line_reg     <= '0;
            base_reg     <= '0;
            rowvalid_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            line_reg     <= line_next;
            base_reg     <= base_next;
            rowvalid_reg <= rowvalid_next;
            m_valid_reg  <= m_valid_next;
        end
        item_reg      <= item_next;
        sweep_row_reg <= sweep_row_next;
        sweep_cnt_reg <= sweep_cnt_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_line_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(line_reg) < MAX_ROWS)
        else $error("cursor row outside the store");

    a_base_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(base_reg) < MAX_ROWS)
        else $error("ring base outside the store");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("screen read and write in the same cycle");

    a_write_valid_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && ram_we) |-> rowvalid_reg[wr_phys])
        else $error("character written into a row not yet filled");

    a_result_after_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_next && !(m_valid_reg && !m_ready)) |-> (state_reg == ST_EXEC))
        else $error("result produced outside the execute step");

endmodule

`default_nettype wire
